>>> rtl/qalu_pkg.sv
// ----------------------------------------------------------------------------
// qalu_pkg: shared types and constants of the Q24.8 fixed-point ALU
// Operation codes, data width and the per-stage divider token.
// ----------------------------------------------------------------------------
`default_nettype none
package qalu_pkg;
	localparam int DataWidth = 32;
	localparam int FracBitsDefault = 8;

	localparam logic [3:0] OP_ADD = 4'd0;
	localparam logic [3:0] OP_SUB = 4'd1;
	localparam logic [3:0] OP_MUL = 4'd2;
	localparam logic [3:0] OP_DIV = 4'd3;
	localparam logic [3:0] OP_MIN = 4'd4;
	localparam logic [3:0] OP_MAX = 4'd5;
	localparam logic [3:0] OP_INC = 4'd6;
	localparam logic [3:0] OP_DEC = 4'd7;
	localparam logic [3:0] OP_TOINT = 4'd8;
	localparam logic [3:0] OP_FROMINT = 4'd9;

	localparam logic signed [63:0] QMax = 64'sd2147483647;
	localparam logic signed [63:0] QMin = -64'sd2147483648;

	// flags and the non-divide result travel alongside the divider row
	typedef struct packed {
		logic        vld;
		logic [3:0]  mode;
		logic [31:0] res;
		logic        gt;
		logic        lt;
		logic        eq;
		logic        ovf;
		logic        dz;
		logic        neg;
	} qalu_side_t;
endpackage
`default_nettype wire

>>> rtl/qalu_stream_if.sv
// ----------------------------------------------------------------------------
// qalu_stream_if: valid/ready channel with a generic payload
// One beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none
interface qalu_stream_if #(parameter type payload_t = logic [31:0]);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/q24_8_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// q24_8_fixed_point_alu: signed Q fixed-point ALU, when not stalled one beat per cycle
// ----------------------------------------------------------------------------
// Fully pipelined: one item accepted per cycle unless the output stalls; the
// depth is set by the row of restoring-division cells (one quotient bit per
// cell, 32+FRACTION_BITS cells); all other operations ride alongside the row.
// The multiplier sits in the first stage, its rounding in the second. The
// whole row advances when the output register is empty or being taken.
`default_nettype none
module q24_8_fixed_point_alu import qalu_pkg::*; #(
	parameter int FRACTION_BITS = FracBitsDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	qalu_stream_if.sink   in_ch,
	qalu_stream_if.source out_ch
);
	localparam int NW = 32 + FRACTION_BITS;
	localparam int NC = NW;

	logic adv;
	logic [3:0]  mode;
	logic signed [31:0] a, b;
	assign mode = in_ch.data.mode;
	assign a = in_ch.data.operand_a;
	assign b = in_ch.data.operand_b;

	// stage 1: simple ops, product, divider operands
	logic signed [63:0] a64, b64, prod, lsh;
	qalu_side_t side_c, side_s1, side_s2;
	logic vld_s1, vld_s2;
	logic signed [63:0] prod_s1;
	logic [NW-1:0] num_c, num_s1, num_s2;
	logic [31:0]   den_c, den_s1, den_s2;

	function automatic logic [31:0] clamp(input logic signed [63:0] v, output logic o);
		o = (v > QMax) || (v < QMin);
		clamp = (v > QMax) ? QMax[31:0] : ((v < QMin) ? QMin[31:0] : v[31:0]);
	endfunction

	function automatic logic [31:0] sgn_sat(input logic n, input logic [63:0] m, output logic o);
		if (n) begin
			o = m > 64'd2147483648;
			sgn_sat = o ? QMin[31:0] : (32'd0 - m[31:0]);
		end else begin
			o = m > 64'd2147483647;
			sgn_sat = o ? QMax[31:0] : m[31:0];
		end
	endfunction

	function automatic logic [31:0] rshift(input logic signed [63:0] v, output logic o);
		logic [63:0] m;
		m = v[63] ? (64'd0 - v) : v;
		m = (m + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
		rshift = sgn_sat(v[63], m, o);
	endfunction

	always_comb begin
		a64 = 64'(a);
		b64 = 64'(b);
		lsh = a64 <<< FRACTION_BITS;
		side_c = '0;
		side_c.vld = in_ch.valid;
		side_c.mode = mode;
		side_c.gt = a > b;
		side_c.lt = a < b;
		side_c.eq = a == b;
		side_c.neg = a[31] ^ b[31];
		unique case (mode)
			OP_ADD: side_c.res = clamp(a64 + b64, side_c.ovf);
			OP_SUB: side_c.res = clamp(a64 - b64, side_c.ovf);
			OP_DIV: side_c.dz = (b == 0);
			OP_MIN: side_c.res = (a < b) ? a : b;
			OP_MAX: side_c.res = (a > b) ? a : b;
			OP_INC: side_c.res = clamp(a64 + 64'sd1, side_c.ovf);
			OP_DEC: side_c.res = clamp(a64 - 64'sd1, side_c.ovf);
			OP_TOINT: side_c.res = rshift(a64, side_c.ovf);
			OP_FROMINT: side_c.res = clamp(lsh, side_c.ovf);
			default: side_c.res = '0;
		endcase
		num_c = NW'(a[31] ? (33'd0 - {1'b1, a}) : {1'b0, a}) << FRACTION_BITS;
		den_c = b[31] ? (32'd0 - b) : b;
	end
	assign prod = a64 * b64;

	logic out_vld_q;
	assign adv = !out_vld_q || out_ch.ready;
	assign in_ch.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_ch.valid;
			vld_s2 <= vld_s1;
		end
	end

	qalu_side_t side_mul;
	always_comb begin
		side_mul = side_s1;
		if (side_s1.mode == OP_MUL) side_mul.res = rshift(prod_s1, side_mul.ovf);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_c;
			prod_s1 <= prod;
			num_s1 <= num_c;
			den_s1 <= den_c;
			side_s2 <= side_mul;
			num_s2 <= num_s1;
			den_s2 <= den_s1;
		end
	end

	// division row, MSB first
	logic [NW-1:0] rem_w [NC+1];
	logic [NW-1:0] num_w [NC+1];
	logic [31:0]   den_w [NC+1];
	logic [NW-1:0] quo_w [NC+1];
	qalu_side_t    side_w [NC+1];
	logic          vld_q [NC+1];
	assign rem_w[0] = '0;
	assign num_w[0] = num_s2;
	assign den_w[0] = den_s2;
	assign quo_w[0] = '0;
	assign side_w[0] = side_s2;
	assign vld_q[0] = vld_s2;

	for (genvar i = 0; i < NC; i++) begin : g_row
		qalu_side_t sraw;
		qalu_div_cell #(.NW(NW), .BIT(NW-1-i)) u_cell (
			.clk, .en(adv), .rem_in(rem_w[i]), .num_in(num_w[i]), .den_in(den_w[i]),
			.quo_in(quo_w[i]), .side_in(side_w[i]), .rem_q(rem_w[i+1]),
			.num_q(num_w[i+1]), .den_q(den_w[i+1]), .quo_q(quo_w[i+1]), .side_q(sraw)
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_q[i+1] <= 1'b0;
			else if (adv) vld_q[i+1] <= vld_q[i];
		end
		always_comb begin
			side_w[i+1] = sraw;
			side_w[i+1].vld = vld_q[i+1];
		end
	end

	// rounding: q = floor(n/d) + (2*rem >= d)
	qalu_side_t fin;
	logic [63:0] qmag;
	always_comb begin
		fin = side_w[NC];
		qmag = 64'(quo_w[NC]) +
			64'(({1'b0, rem_w[NC]} << 1) >= {{(NW-31){1'b0}}, den_w[NC]});
		if (fin.mode == OP_DIV) begin
			if (fin.dz) begin
				fin.res = '0;
				fin.ovf = 1'b0;
			end else fin.res = sgn_sat(fin.neg, qmag, fin.ovf);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (adv) out_vld_q <= fin.vld;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_ch.data.result <= fin.res;
			out_ch.data.a_greater <= fin.gt;
			out_ch.data.a_less <= fin.lt;
			out_ch.data.a_equal <= fin.eq;
			out_ch.data.overflow <= fin.ovf;
			out_ch.data.div_by_zero <= fin.dz;
		end
	end
	assign out_ch.valid = out_vld_q;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !out_ch.ready |=> out_vld_q && $stable(out_ch.data.result))
		else $error("output beat dropped");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> $countones({out_ch.data.a_greater, out_ch.data.a_less,
			out_ch.data.a_equal}) == 1)
		else $error("compare flags not exclusive");
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_ch.data.div_by_zero |-> out_ch.data.result == 0 &&
			!out_ch.data.overflow)
		else $error("divide by zero result");
endmodule
`default_nettype wire

>>> rtl/qalu_div_cell.sv
// ----------------------------------------------------------------------------
// qalu_div_cell: one restoring-division step
// Shifts in one dividend bit, conditionally subtracts the divisor.
// ----------------------------------------------------------------------------
`default_nettype none
module qalu_div_cell import qalu_pkg::*; #(
	parameter int NW = 41,
	parameter int BIT = 0
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [NW-1:0] rem_in,
	input  wire logic [NW-1:0] num_in,
	input  wire logic [31:0]   den_in,
	input  wire logic [NW-1:0] quo_in,
	input  wire qalu_side_t    side_in,
	output logic [NW-1:0]      rem_q,
	output logic [NW-1:0]      num_q,
	output logic [31:0]        den_q,
	output logic [NW-1:0]      quo_q,
	output qalu_side_t         side_q
);
	logic [NW:0] trial;
	logic [NW:0] shifted;
	logic [NW-1:0] quo_nx;
	assign shifted = {rem_in, num_in[BIT]};
	assign trial = shifted - {{(NW-31){1'b0}}, den_in};

	always_comb begin
		quo_nx = quo_in;
		quo_nx[BIT] = ~trial[NW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_q <= num_in;
			den_q <= den_in;
			side_q <= side_in;
			quo_q <= quo_nx;
			rem_q <= trial[NW] ? shifted[NW-1:0] : trial[NW-1:0];
		end
	end
endmodule
`default_nettype wire
